/* hw/rtl/gls_pkg.sv */
// Shared types, constants and helper functions for the grayscale LED scan block.
package gls_pkg;

   localparam int ROW_COUNT_DEF  = 48;
   localparam int PWM_PASSES_DEF = 15;

   localparam int ROW_W        = 6;
   localparam int LEVEL_W      = 4;
   localparam int PHASE_W      = 3;
   localparam int BYTE_COUNT_W = 9;
   localparam int LANES        = 8;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [PHASE_W-1:0] LOAD_PHASE = 3'd6;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_data_type;

   typedef struct packed {
      logic                    result_kind;
      logic [7:0]              column_first;
      logic [7:0]              column_second;
      logic [7:0]              select_port_low;
      logic [6:0]              select_port_high;
      logic [ROW_W-1:0]        row_number;
      logic [LEVEL_W-1:0]      pwm_level;
      logic [PHASE_W-1:0]      receiver_phase;
      logic [BYTE_COUNT_W-1:0] load_count;
      logic                    frame_complete;
   } rsp_data_type;

   // Expected byte of the frame header at each match position.
   function automatic logic [7:0] header_byte(input logic [PHASE_W-1:0] phase);
      logic [7:0] value;
      case (phase)
         3'd0: value = 8'hde;
         3'd1: value = 8'had;
         3'd2: value = 8'hbe;
         3'd3: value = 8'hef;
         3'd4: value = 8'h01;
         3'd5: value = 8'h02;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

   // Eight packed 4-bit pixels against the level: bit i set when pixel i is greater.
   function automatic logic [7:0] compare_byte(input logic [31:0] pixels,
                                               input logic [LEVEL_W-1:0] level);
      logic [7:0] bits;
      bits = '0;
      for (int i = 0; i < 8; i++) begin
         bits[i] = (pixels[4*i +: 4] > level);
      end
      return bits;
   endfunction

endpackage

/* hw/rtl/grayscale_led_scan_with_frame_loader.sv */
// Top level: serial frame loader and PWM row scan for a 16-column LED matrix.
//
// Input channel (req_*): each beat is either a received serial byte or a refresh
// tick. Bytes run through a header matcher (DE AD BE EF 01 02); after a full
// header the next ROW_COUNT*8 bytes fill the frame store in order. A tick steps
// the PWM level and, at wrap, the scan row, then drives that row: two column
// bytes (pixel on when its value exceeds the level) and the row-select ports.
// Result channel (rsp_*): exactly one beat per input beat, in order.
// Result path: the frame store row read and the read stage register when the input
// beat is accepted; the output register loads from the read stage once the output
// is free, so a stall can hold an item in the read stage.
// Throughput: one beat per cycle unless stalled; the frame store is eight byte-lane
// RAMs, so a byte write and a row read each take one port access per item.
// Reset: the scan sits at the last row and level so the first tick shows row 0
// at level 0; the header matcher restarts. The frame store is not cleared: a
// fill count marks which bytes were loaded since reset, and the rest read as
// 0xFF, so the block takes beats as soon as reset is released.
// Stalls: when rsp_ready is low the result and one item in flight are held, and
// req_ready drops while that item waits, until the output frees up.
module grayscale_led_scan_with_frame_loader
   import gls_pkg::*;
#(
   parameter int ROW_COUNT  = ROW_COUNT_DEF,
   parameter int PWM_PASSES = PWM_PASSES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   localparam int ADDR_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam logic [BYTE_COUNT_W-1:0] FRAME_BYTES = BYTE_COUNT_W'(ROW_COUNT * LANES);
   localparam logic [ROW_W-1:0]        LAST_ROW    = ROW_W'(ROW_COUNT - 1);
   localparam logic [LEVEL_W-1:0]      LAST_LEVEL  = LEVEL_W'(PWM_PASSES - 1);

   // scan and receiver state
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [LEVEL_W-1:0]      level_ff, level_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [BYTE_COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_COUNT_W-1:0] fill_ff, fill_in;

   // read stage and output register
   logic               s1_valid_ff;
   rsp_data_type       s1_rsp_ff, s1_rsp_in;
   logic [LANES-1:0]   s1_mask_ff, s1_mask_in;
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic rsp_move, s1_move, accept, is_tick, done;
   logic [BYTE_COUNT_W-1:0] count_next;
   logic [ROW_W-1:0]  wr_row;
   logic [2:0]        wr_lane;
   logic              wr_en;
   logic [LANES-1:0]  lane_we;
   logic [7:0]        lane_rd [LANES];
   logic [7:0]        lane_val [LANES];
   logic [7:0]        port_low, port_high_byte;

   assign rsp_move  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = !s1_valid_ff || rsp_move;
   assign req_ready = s1_move;
   assign accept    = req_valid && req_ready;
   assign is_tick   = (req_data.command == CMD_TICK);

   assign count_next = count_ff + BYTE_COUNT_W'(1);
   assign wr_row     = count_ff[BYTE_COUNT_W-1:3];
   assign wr_lane    = count_ff[2:0];

   always_comb begin
      row_in   = row_ff;
      level_in = level_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      fill_in  = fill_ff;
      wr_en    = 1'b0;
      done     = 1'b0;
      if (accept) begin
         if (is_tick) begin
            if (level_ff == LAST_LEVEL) begin
               level_in = '0;
               row_in   = (row_ff == LAST_ROW) ? '0 : row_ff + ROW_W'(1);
            end else begin
               level_in = level_ff + LEVEL_W'(1);
            end
         end else if (phase_ff != LOAD_PHASE) begin
            // restart on mismatch without rechecking this byte
            if (req_data.rx_byte == header_byte(phase_ff)) begin
               phase_in = phase_ff + PHASE_W'(1);
               if (phase_ff == LOAD_PHASE - PHASE_W'(1)) begin
                  count_in = '0;
               end
            end else begin
               phase_in = '0;
            end
         end else begin
            wr_en    = 1'b1;
            count_in = count_next;
            if (count_next > fill_ff) begin
               fill_in = count_next;
            end
            if (count_next == FRAME_BYTES) begin
               phase_in = '0;
               done     = 1'b1;
            end
         end
      end
   end

   // row-select ports for the row this tick drives
   always_comb begin
      if (row_in <= ROW_W'(15)) begin
         port_low       = {2'b00, row_in};
         port_high_byte = 8'h60;
      end else if (row_in <= ROW_W'(31)) begin
         port_low       = {row_in[3:0], 4'h0};
         port_high_byte = 8'h50;
      end else begin
         port_low       = 8'h00;
         port_high_byte = {4'h3, row_in[3:0]};
      end
   end

   always_comb begin
      s1_rsp_in                  = '0;
      s1_rsp_in.result_kind      = req_data.command;
      s1_rsp_in.row_number       = row_in;
      s1_rsp_in.pwm_level        = level_in;
      s1_rsp_in.receiver_phase   = phase_in;
      s1_rsp_in.load_count       = count_in;
      s1_rsp_in.frame_complete   = done;
      if (is_tick) begin
         s1_rsp_in.select_port_low  = port_low;
         s1_rsp_in.select_port_high = port_high_byte[6:0];
      end
      // a byte never loaded since reset reads as 0xFF
      for (int k = 0; k < LANES; k++) begin
         s1_mask_in[k] = ({row_in, 3'(k)} < fill_ff);
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      assign lane_we[k] = wr_en && (wr_lane == 3'(k));

      gls_ram #(
         .WIDTH(8),
         .DEPTH(ROW_COUNT)
      ) u_lane_ram (
         .clock  (clock),
         .wr_en  (lane_we[k]),
         .wr_addr(wr_row[ADDR_W-1:0]),
         .wr_data(req_data.rx_byte),
         .rd_en  (accept && is_tick),
         .rd_addr(row_in[ADDR_W-1:0]),
         .rd_data(lane_rd[k])
      );

      assign lane_val[k] = s1_mask_ff[k] ? lane_rd[k] : 8'hFF;
   end

   always_comb begin
      rsp_data_in = s1_rsp_ff;
      if (s1_rsp_ff.result_kind == CMD_TICK) begin
         rsp_data_in.column_second = compare_byte(
            {lane_val[3], lane_val[2], lane_val[1], lane_val[0]}, s1_rsp_ff.pwm_level);
         rsp_data_in.column_first  = compare_byte(
            {lane_val[7], lane_val[6], lane_val[5], lane_val[4]}, s1_rsp_ff.pwm_level);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= LAST_ROW;
         level_ff     <= LAST_LEVEL;
         phase_ff     <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         level_ff <= level_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
         if (s1_move) begin
            s1_valid_ff <= accept;
         end
         if (rsp_move) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff  <= s1_rsp_in;
         s1_mask_ff <= s1_mask_in;
      end
      if (rsp_move && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fill_covers_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fill_ff)
      else $error("load count ran past the fill count");

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == LOAD_PHASE |-> count_ff < FRAME_BYTES)
      else $error("loading with a full frame count");

   a_read_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_move |=> s1_valid_ff && $stable(s1_mask_ff)
                                   && $stable(s1_rsp_ff))
      else $error("read stage changed while stalled");

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && done |=> phase_ff == '0)
      else $error("header matcher did not restart after a full frame");

endmodule

/* hw/rtl/gls_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
